>>> sv/mer_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the midpoint ellipse rasterizer.
// Depends on nothing; used by every module of the block.
package mer_pkg;

    localparam int RADIUS_BITS_DEF = 11;
    localparam int RADIUS_REG_W    = 11;
    localparam int CENTER_W        = 12;
    localparam int COORD_W         = 14;
    localparam int CFG_ADDR_W      = 2;
    localparam int CFG_DATA_W      = 12;
    localparam int S_DATA_W        = 8;
    localparam int M_DATA_W        = 4 * COORD_W;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 2'd3;

    typedef struct packed {
        logic                      valid_res;
        logic signed [COORD_W-1:0] x_plus;
        logic signed [COORD_W-1:0] x_minus;
        logic signed [COORD_W-1:0] y_plus;
        logic signed [COORD_W-1:0] y_minus;
        logic                      last;
    } res_t;

    typedef struct packed {
        logic accept;
        logic restart;
        logic out_free;
    } seq_ctrl_t;

    typedef struct packed {
        logic ready;
        logic load;
    } seq_stat_t;

endpackage

>>> sv/mer_mult.sv
`timescale 1ns / 1ps
// Shared multiplier of the rasterizer: one product per cycle, registered.
// Depends on mer_pkg for width defaults.
module mer_mult #(
    parameter int OP_W   = 2 * mer_pkg::RADIUS_BITS_DEF + 4,
    parameter int PROD_W = 4 * mer_pkg::RADIUS_BITS_DEF + 4
) (
    input  logic              aclk,
    input  logic [OP_W-1:0]   op_a,
    input  logic [OP_W-1:0]   op_b,
    output logic [PROD_W-1:0] prod
);
    import mer_pkg::*;

    logic [2*OP_W-1:0] full;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign full      = op_a * op_b;
    assign prod_next = full[PROD_W-1:0];
    assign prod      = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

>>> sv/mer_seq.sv
`timescale 1ns / 1ps
// Walk sequencer of the rasterizer: point state, decision variable and the
// step sequence around the shared multiplier. Depends on mer_pkg, mer_mult.
module mer_seq #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mer_pkg::seq_ctrl_t                ctrl,
    input  logic [mer_pkg::RADIUS_REG_W-1:0]  radius_x,
    input  logic [mer_pkg::RADIUS_REG_W-1:0]  radius_y,
    input  logic [mer_pkg::CENTER_W-1:0]      center_x,
    input  logic [mer_pkg::CENTER_W-1:0]      center_y,
    output mer_pkg::seq_stat_t                stat,
    output mer_pkg::res_t                     res
);
    import mer_pkg::*;

    localparam int RB   = RADIUS_BITS;
    localparam int SQ_W = 2 * RB;
    localparam int PA_W = 3 * RB + 1;
    localparam int DW   = 4 * RB + 4;
    localparam int MW   = 2 * RB + 4;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQX  = 4'd1;
    localparam logic [3:0] S_SQY  = 4'd2;
    localparam logic [3:0] S_INIT = 4'd3;
    localparam logic [3:0] S_OUT  = 4'd4;
    localparam logic [3:0] S_ADV  = 4'd5;
    localparam logic [3:0] S_P1   = 4'd6;
    localparam logic [3:0] S_P2   = 4'd7;
    localparam logic [3:0] S_UPD  = 4'd8;
    localparam logic [3:0] S_T1   = 4'd9;
    localparam logic [3:0] S_T2   = 4'd10;
    localparam logic [3:0] S_T3   = 4'd11;
    localparam logic [3:0] S_T4   = 4'd12;
    localparam logic [3:0] S_T5   = 4'd13;
    localparam logic [3:0] S_T6   = 4'd14;
    localparam logic [3:0] S_EMIT = 4'd15;

    localparam logic [1:0] BR_ONE_X  = 2'd0;
    localparam logic [1:0] BR_ONE_XY = 2'd1;
    localparam logic [1:0] BR_TWO_Y  = 2'd2;
    localparam logic [1:0] BR_TWO_XY = 2'd3;

    logic [3:0]      state_reg, state_next;
    logic            restart_reg, restart_next;
    logic [RB-1:0]   offset_x_reg, offset_x_next;
    logic [RB-1:0]   offset_y_reg, offset_y_next;
    logic [DW-1:0]   decision_reg, decision_next;
    logic            region2_reg, region2_next;
    logic            finished_reg, finished_next;
    logic [SQ_W-1:0] rx2_reg, rx2_next;
    logic [SQ_W-1:0] ry2_reg, ry2_next;
    logic [RB:0]     walk_x_reg, walk_x_next;
    logic [RB-1:0]   walk_y_reg, walk_y_next;
    logic [1:0]      branch_reg, branch_next;
    logic [PA_W-1:0] pa_reg, pa_next;
    logic [MW-1:0]   tmp_reg, tmp_next;
    res_t            res_reg, res_next;

    logic [MW-1:0]   op_a, op_b;
    logic [DW-1:0]   prod;
    logic [PA_W-1:0] pb;

    logic [RB+RADIUS_REG_W-1:0] rx_ext, ry_ext;
    logic [RB-1:0]              rx, ry;
    logic [RB+COORD_W-1:0]      ox_ext, oy_ext;
    logic [COORD_W-1:0]         ox_c, oy_c, cx_c, cy_c;
    logic                       dec_neg, dec_pos, is_last;
    logic [RB:0]                x_inc;
    logic [RB+1:0]              t_val;
    logic [RB-1:0]              ym_abs;
    logic [DW-1:0]              add_term, sub_term, cst_term;

    assign rx_ext = {{RB{1'b0}}, radius_x};
    assign ry_ext = {{RB{1'b0}}, radius_y};
    assign rx     = rx_ext[RB-1:0];
    assign ry     = ry_ext[RB-1:0];
    assign ox_ext = {{COORD_W{1'b0}}, offset_x_reg};
    assign oy_ext = {{COORD_W{1'b0}}, offset_y_reg};
    assign ox_c   = ox_ext[COORD_W-1:0];
    assign oy_c   = oy_ext[COORD_W-1:0];
    assign cx_c   = COORD_W'(center_x);
    assign cy_c   = COORD_W'(center_y);

    assign dec_neg = decision_reg[DW-1];
    assign dec_pos = !dec_neg && (decision_reg != '0);
    assign is_last = (offset_y_reg == '0) && (region2_reg || (offset_x_reg >= rx));
    assign x_inc   = {1'b0, offset_x_reg} + (RB+1)'(1);
    assign t_val   = {walk_x_reg, 1'b1};
    assign ym_abs  = (walk_y_reg == '0) ? RB'(1) : walk_y_reg - RB'(1);
    assign pb      = prod[PA_W-1:0];

    assign add_term = (branch_reg == BR_TWO_Y) ? '0 : (DW'(pa_reg) << 3);
    assign sub_term = (branch_reg == BR_ONE_X) ? '0 : (DW'(pb) << 3);
    assign cst_term = region2_reg ? (DW'(rx2_reg) << 2) : (DW'(ry2_reg) << 2);

    mer_mult #(
        .OP_W   (MW),
        .PROD_W (DW)
    ) u_mult (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_SQX: begin
                op_a = MW'(rx);
                op_b = MW'(rx);
            end
            S_SQY: begin
                op_a = MW'(ry);
                op_b = MW'(ry);
            end
            S_INIT: begin
                op_a = MW'(rx2_reg);
                op_b = MW'(ry);
            end
            S_P1: begin
                op_a = MW'(ry2_reg);
                op_b = MW'(walk_x_reg);
            end
            S_P2: begin
                op_a = MW'(rx2_reg);
                op_b = MW'(walk_y_reg);
            end
            S_T1: begin
                op_a = MW'(t_val);
                op_b = MW'(t_val);
            end
            S_T2: begin
                op_a = MW'(ym_abs);
                op_b = MW'(ym_abs);
            end
            S_T3: begin
                op_a = MW'(ry2_reg);
                op_b = tmp_reg;
            end
            S_T4: begin
                op_a = MW'(rx2_reg);
                op_b = tmp_reg;
            end
            S_T5: begin
                op_a = MW'(rx2_reg);
                op_b = MW'(ry2_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        restart_next  = restart_reg;
        offset_x_next = offset_x_reg;
        offset_y_next = offset_y_reg;
        decision_next = decision_reg;
        region2_next  = region2_reg;
        finished_next = finished_reg;
        rx2_next      = rx2_reg;
        ry2_next      = ry2_reg;
        walk_x_next   = walk_x_reg;
        walk_y_next   = walk_y_reg;
        branch_next   = branch_reg;
        pa_next       = pa_reg;
        tmp_next      = tmp_reg;
        res_next      = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (ctrl.accept) begin
                    restart_next = ctrl.restart;
                    state_next   = S_SQX;
                end
            end
            S_SQX: begin
                state_next = S_SQY;
            end
            S_SQY: begin
                rx2_next   = prod[SQ_W-1:0];
                state_next = S_INIT;
            end
            S_INIT: begin
                ry2_next = prod[SQ_W-1:0];
                if (restart_reg) begin
                    offset_x_next = '0;
                    offset_y_next = ry;
                    finished_next = 1'b0;
                    region2_next  = (rx == '0);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (restart_reg) begin
                    if (rx == '0) begin
                        decision_next = DW'(ry2_reg);
                    end else begin
                        decision_next = (DW'(ry2_reg) << 2) - (prod << 2) + DW'(rx2_reg);
                    end
                end
                if (finished_reg) begin
                    res_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    res_next.valid_res = 1'b1;
                    res_next.x_plus    = cx_c + ox_c;
                    res_next.x_minus   = cx_c - ox_c;
                    res_next.y_plus    = cy_c + oy_c;
                    res_next.y_minus   = cy_c - oy_c;
                    res_next.last      = is_last;
                    if (is_last) begin
                        finished_next = 1'b1;
                        state_next    = S_EMIT;
                    end else begin
                        state_next = S_ADV;
                    end
                end
            end
            S_ADV: begin
                if (!region2_reg) begin
                    if (offset_y_reg == '0) begin
                        offset_x_next = x_inc[RB-1:0];
                        state_next    = S_EMIT;
                    end else begin
                        walk_x_next = x_inc;
                        walk_y_next = dec_neg ? offset_y_reg : offset_y_reg - RB'(1);
                        branch_next = dec_neg ? BR_ONE_X : BR_ONE_XY;
                        state_next  = S_P1;
                    end
                end else begin
                    walk_x_next = dec_pos ? {1'b0, offset_x_reg} : x_inc;
                    walk_y_next = offset_y_reg - RB'(1);
                    branch_next = dec_pos ? BR_TWO_Y : BR_TWO_XY;
                    state_next  = S_P1;
                end
            end
            S_P1: begin
                state_next = S_P2;
            end
            S_P2: begin
                pa_next    = prod[PA_W-1:0];
                state_next = S_UPD;
            end
            S_UPD: begin
                decision_next = decision_reg + add_term - sub_term + cst_term;
                offset_x_next = walk_x_reg[RB-1:0];
                offset_y_next = walk_y_reg;
                if (!region2_reg && (pa_reg > pb)) begin
                    region2_next = 1'b1;
                    state_next   = S_T1;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_T1: begin
                state_next = S_T2;
            end
            S_T2: begin
                tmp_next   = prod[MW-1:0];
                state_next = S_T3;
            end
            S_T3: begin
                tmp_next   = prod[MW-1:0];
                state_next = S_T4;
            end
            S_T4: begin
                decision_next = prod;
                state_next    = S_T5;
            end
            S_T5: begin
                decision_next = decision_reg + (prod << 2);
                state_next    = S_T6;
            end
            S_T6: begin
                decision_next = decision_reg - (prod << 2);
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (ctrl.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            restart_reg  <= 1'b0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            decision_reg <= '0;
            region2_reg  <= 1'b0;
            finished_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            restart_reg  <= restart_next;
            offset_x_reg <= offset_x_next;
            offset_y_reg <= offset_y_next;
            decision_reg <= decision_next;
            region2_reg  <= region2_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge aclk) begin
        rx2_reg    <= rx2_next;
        ry2_reg    <= ry2_next;
        walk_x_reg <= walk_x_next;
        walk_y_reg <= walk_y_next;
        branch_reg <= branch_next;
        pa_reg     <= pa_next;
        tmp_reg    <= tmp_next;
        res_reg    <= res_next;
    end

    assign stat.ready = (state_reg == S_IDLE);
    assign stat.load  = (state_reg == S_EMIT) && ctrl.out_free;
    assign res        = res_reg;

endmodule

>>> sv/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps
// Midpoint ellipse rasterizer: configuration registers, request handshake and
// output register around the walk sequencer. Depends on mer_pkg, mer_seq.
//
// Usage:
//   Write radius_x, radius_y, center_x, center_y over the cfg port (index 0..3)
//   while the block is idle; cfg_ready is high whenever reset is released.
//   Each request on s_* (s_tdata[0] = restart) yields exactly one result on m_*:
//   four mirrored coordinates of the current point in m_tdata, the plot flag
//   in m_tuser and the final-point flag in m_tlast. A restart request begins a
//   new ellipse at (0, radius_y); later requests advance one step each.
//   After the final point every request returns m_tuser = 0 and zero data.
//   The work per request differs for an idle or final point, an axis step, a
//   normal step and the step that enters the second region, which computes
//   the new decision variable. Each request runs its products through the
//   one shared multiplier, which squares the radii again for every request.
//   s_tready is low while a request is in work and during reset. A stalled
//   receiver holds the result in the output register; the next request is
//   taken meanwhile and its result waits until the register frees.
//   Reset clears the configuration registers to zero and leaves nothing to draw.
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mer_pkg::S_DATA_W-1:0]      s_tdata,   // [0] restart
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mer_pkg::M_DATA_W-1:0]      m_tdata,   // x_plus, x_minus, y_plus, y_minus
    output logic                              m_tuser,   // valid_res
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mer_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [mer_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mer_pkg::*;

    logic [RADIUS_REG_W-1:0] radius_x_reg, radius_y_reg;
    logic [CENTER_W-1:0]     center_x_reg, center_y_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    res_t                    out_reg;
    res_t                    seq_res;
    seq_ctrl_t               ctrl;
    seq_stat_t               stat;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_x_reg <= '0;
            radius_y_reg <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RADIUS_X: radius_x_reg <= cfg_data[RADIUS_REG_W-1:0];
                REG_RADIUS_Y: radius_y_reg <= cfg_data[RADIUS_REG_W-1:0];
                REG_CENTER_X: center_x_reg <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y: center_y_reg <= cfg_data[CENTER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign ctrl.accept   = s_tvalid && s_tready;
    assign ctrl.restart  = s_tdata[0];
    assign ctrl.out_free = !m_tvalid_reg || m_tready;
    assign s_tready      = stat.ready && aresetn;

    mer_seq #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .radius_x (radius_x_reg),
        .radius_y (radius_y_reg),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .stat     (stat),
        .res      (seq_res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (stat.load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.load) begin
            out_reg <= seq_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.y_minus, out_reg.y_plus, out_reg.x_minus, out_reg.x_plus};
    assign m_tuser  = out_reg.valid_res;
    assign m_tlast  = out_reg.last;

endmodule
